// ===== hw/rtl/dwmm_pkg.sv =====
// ---------------------------------------------------------------------------
// dwmm_pkg
// shared types, constants and register codes for the dequantizing
// weight matrix multiply block
// ---------------------------------------------------------------------------
package dwmm_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_DEPTH   = 1024;

    localparam int COL_IDX_W    = 6;
    localparam int DEPTH_IDX_W  = 10;
    localparam int ADDR_MAX_W   = 18;
    localparam int WEIGHT_W     = 8;
    localparam int ACT_W        = 16;
    localparam int SCALE_W      = 16;
    localparam int ZP_W         = 8;
    localparam int DEPTH_USED_W = 11;
    localparam int COLS_USED_W  = 7;
    localparam int SUM_W        = 36;
    localparam int RESULT_W     = 53;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_USED   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_USED = 2'd3;

    localparam logic ACT_LOAD_WEIGHT = 1'b0;
    localparam logic ACT_ACTIVATION  = 1'b1;

    typedef struct packed {
        logic                          action;
        logic [COL_IDX_W-1:0]          weight_row;
        logic [DEPTH_IDX_W-1:0]        weight_col;
        logic [WEIGHT_W-1:0]           weight_value;
        logic signed [ACT_W-1:0]       act_value;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0]    result_value;
        logic [COL_IDX_W-1:0]          out_column;
        logic                          last_in_row;
    } result_t;

    typedef struct packed {
        logic [ZP_W-1:0]               zero_point;
        logic signed [SCALE_W-1:0]     scale;
        logic [DEPTH_USED_W-1:0]       depth_used;
        logic [COLS_USED_W-1:0]        columns_used;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        zero_point:   8'd0,
        scale:        16'sd4096,
        depth_used:   11'd1024,
        columns_used: 7'd64
    };

    typedef struct packed {
        logic                          in_take;
        logic                          acc_issue;
        logic                          sum_rd;
        logic                          out_load;
        logic                          last;
        logic                          clear_sums;
        logic [COL_IDX_W-1:0]          col;
        logic [ADDR_MAX_W-1:0]         waddr;
    } dp_cmd_t;

    typedef struct packed {
        logic                          pipe_busy;
    } dp_status_t;

endpackage

// ===== hw/rtl/dwmm_cfg.sv =====
// ---------------------------------------------------------------------------
// dwmm_cfg
// configuration registers, written through the plain write port
// ---------------------------------------------------------------------------
module dwmm_cfg
    import dwmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ZERO_POINT:   cfg_reg.zero_point   <= cfg_data[ZP_W-1:0];
                REG_SCALE:        cfg_reg.scale        <= $signed(cfg_data[SCALE_W-1:0]);
                REG_DEPTH_USED:   cfg_reg.depth_used   <= cfg_data[DEPTH_USED_W-1:0];
                REG_COLUMNS_USED: cfg_reg.columns_used <= cfg_data[COLS_USED_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/dwmm_ctrl.sv =====
// ---------------------------------------------------------------------------
// dwmm_ctrl
// controller: sequences the column sweep per activation item and the
// column by column result emission at the end of a row
// ---------------------------------------------------------------------------
module dwmm_ctrl
    import dwmm_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       item_valid,
    input  logic       item_action,
    output logic       item_stall,
    output logic       result_valid,
    input  logic       result_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int DW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int AW  = (MAX_COLUMNS * MAX_DEPTH > 1) ? $clog2(MAX_COLUMNS * MAX_DEPTH) : 1;
    localparam int EW0 = $clog2(MAX_DEPTH + 1);
    localparam int EW  = (EW0 > DEPTH_USED_W) ? EW0 : DEPTH_USED_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ACC      = 3'd1;
    localparam logic [2:0] S_DRAIN    = 3'd2;
    localparam logic [2:0] S_OUT_RD   = 3'd3;
    localparam logic [2:0] S_OUT_MUL  = 3'd4;
    localparam logic [2:0] S_OUT_WAIT = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [DW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] waddr_reg, waddr_next;

    logic [EW-1:0]          depth_ext;
    logic [EW-1:0]          eff_depth;
    logic [EW-1:0]          cnt_inc;
    logic                   row_done;
    logic [COLS_USED_W-1:0] eff_cols;
    logic [COLS_USED_W-1:0] last_col;
    logic                   is_last;

    always_comb
    begin
        depth_ext = EW'(cfg.depth_used);
        if (depth_ext == '0)
            eff_depth = EW'(1);
        else if (depth_ext > EW'(MAX_DEPTH))
            eff_depth = EW'(MAX_DEPTH);
        else
            eff_depth = depth_ext;
        cnt_inc  = EW'(cnt_reg) + EW'(1);
        row_done = (cnt_inc >= eff_depth);

        if (cfg.columns_used == '0)
            eff_cols = COLS_USED_W'(1);
        else if (cfg.columns_used > COLS_USED_W'(MAX_COLUMNS))
            eff_cols = COLS_USED_W'(MAX_COLUMNS);
        else
            eff_cols = cfg.columns_used;
        last_col = eff_cols - COLS_USED_W'(1);
        is_last  = (COLS_USED_W'(col_reg) == last_col);
    end

    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        cnt_next     = cnt_reg;
        waddr_next   = waddr_reg;
        item_stall   = 1'b1;
        result_valid = 1'b0;
        cmd          = '0;
        cmd.col      = COL_IDX_W'(col_reg);
        cmd.waddr    = ADDR_MAX_W'(waddr_reg);

        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.in_take = 1'b1;
                    if (item_action == ACT_ACTIVATION)
                    begin
                        state_next = S_ACC;
                        col_next   = '0;
                        waddr_next = AW'(cnt_reg);
                    end
                end
            end
            S_ACC:
            begin
                cmd.acc_issue = 1'b1;
                if (is_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    col_next   = col_reg + CW'(1);
                    waddr_next = waddr_reg + AW'(MAX_DEPTH);
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    col_next = '0;
                    if (row_done)
                    begin
                        cnt_next   = '0;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        cnt_next   = cnt_inc[DW-1:0];
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT_RD:
            begin
                cmd.sum_rd = 1'b1;
                state_next = S_OUT_MUL;
            end
            S_OUT_MUL:
            begin
                cmd.out_load = 1'b1;
                cmd.last     = is_last;
                state_next   = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                result_valid = 1'b1;
                if (!result_stall)
                begin
                    if (is_last)
                    begin
                        cmd.clear_sums = 1'b1;
                        col_next       = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + CW'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            cnt_reg   <= '0;
            waddr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            waddr_reg <= waddr_next;
        end
    end

endmodule

// ===== hw/rtl/dwmm_dp.sv =====
// ---------------------------------------------------------------------------
// dwmm_dp
// datapath: weight store, column sum memory, multiply accumulate pipe
// and the scaling multiplier with the result register
// ---------------------------------------------------------------------------
module dwmm_dp
    import dwmm_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  in_item_t   item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output result_t    result
);

    localparam int CW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int WDEPTH = MAX_COLUMNS * MAX_DEPTH;
    localparam int AW     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int PROD_W = ACT_W + WEIGHT_W + 1;
    localparam int OUT_W  = SUM_W + SCALE_W;

    logic [WEIGHT_W-1:0]     wmem [WDEPTH];
    logic signed [SUM_W-1:0] smem [MAX_COLUMNS];

    logic [MAX_COLUMNS-1:0]   sval_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [ACT_W-1:0]  act_reg;
    logic [WEIGHT_W-1:0]      wrd_reg;
    logic signed [SUM_W-1:0]  srd_reg;
    logic                     svld1_reg;
    logic [CW-1:0]            c1_reg;
    logic [CW-1:0]            c2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum2_reg;
    result_t                  result_reg;

    logic [ADDR_MAX_W-1:0]    wr_lin;
    logic                     wr_ok;
    logic                     wr_en;
    logic signed [WEIGHT_W:0] wdiff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [SUM_W-1:0]  sum_m;
    logic signed [SUM_W-1:0]  sum_new;
    logic signed [OUT_W-1:0]  scaled;

    always_comb
    begin
        wr_lin = ADDR_MAX_W'(item.weight_row) * ADDR_MAX_W'(MAX_DEPTH)
               + ADDR_MAX_W'(item.weight_col);
        wr_ok  = (int'(item.weight_row) < MAX_COLUMNS) && (int'(item.weight_col) < MAX_DEPTH);
        wr_en  = cmd.in_take && (item.action == ACT_LOAD_WEIGHT) && wr_ok;

        wdiff     = $signed({1'b0, wrd_reg}) - $signed({1'b0, cfg.zero_point});
        prod_next = PROD_W'(wdiff) * PROD_W'(act_reg);
        sum_m     = svld1_reg ? srd_reg : '0;
        sum_new   = sum2_reg + SUM_W'(prod_reg);
        scaled    = OUT_W'(sum_m) * OUT_W'(cfg.scale);
    end

    // weight store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            wmem[wr_lin[AW-1:0]] <= item.weight_value;
        if (cmd.acc_issue)
            wrd_reg <= wmem[cmd.waddr[AW-1:0]];
    end

    // column sum store
    always_ff @(posedge clk)
    begin
        if (v2_reg)
            smem[c2_reg] <= sum_new;
        if (cmd.acc_issue || cmd.sum_rd)
            srd_reg <= smem[cmd.col[CW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            sval_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd.acc_issue;
            v2_reg <= v1_reg;
            if (cmd.clear_sums)
                sval_reg <= '0;
            else if (v2_reg)
                sval_reg[c2_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_take && (item.action == ACT_ACTIVATION))
            act_reg <= item.act_value;
        if (cmd.acc_issue || cmd.sum_rd)
            svld1_reg <= sval_reg[cmd.col[CW-1:0]];
        c1_reg   <= cmd.col[CW-1:0];
        c2_reg   <= c1_reg;
        prod_reg <= prod_next;
        sum2_reg <= sum_m;
        if (cmd.out_load)
        begin
            result_reg.result_value <= RESULT_W'(scaled);
            result_reg.out_column   <= cmd.col;
            result_reg.last_in_row  <= cmd.last;
        end
    end

    assign status.pipe_busy = v1_reg | v2_reg;
    assign result           = result_reg;

endmodule

// ===== hw/rtl/dequant_weight_matrix_multiply.sv =====
// ---------------------------------------------------------------------------
// dequant_weight_matrix_multiply
// fully connected layer with 8-bit weights, one zero point and one scale
// ---------------------------------------------------------------------------
// weight load item: taken when idle, the next item may follow at once
// activation item: one column per cycle through the shared 16x9 multiplier
//   and the sum memory (one read, one write port), then a drain of the pipe
// row end: per result a sum read and the 36x16 scaling multiplier, plus stall
// reset clears config to defaults and all column sums; weight store is
//   undefined until written, no clearing pass
module dequant_weight_matrix_multiply
    import dwmm_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_item_t              item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    dwmm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dwmm_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_DEPTH   (MAX_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_action  (item.action),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    dwmm_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_DEPTH   (MAX_DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

// ===== hw/rtl/dwmm_checker.sv =====
// ---------------------------------------------------------------------------
// dwmm_checker
// port level checks for the dequantizing weight matrix multiply block
// ---------------------------------------------------------------------------
module dwmm_checker
    import dwmm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_stall,
    input in_item_t              item,
    input logic                  result_valid,
    input logic                  result_stall,
    input result_t               result
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result item changed");

    // no item taken while a row is being emitted
    a_no_take_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("input open while results pending");

    // a weight load leaves the block ready
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.action == ACT_LOAD_WEIGHT) |=> !item_stall)
        else $error("weight load did not complete in one cycle");

    // results are spaced by the read and multiply steps
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall |=> !result_valid)
        else $error("result valid right after a taken result");

    // columns come out in order within a row
    a_column_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last_in_row |-> ##3
        (result_valid &&
         result.out_column == COL_IDX_W'($past(result.out_column, 3) + COL_IDX_W'(1))))
        else $error("result column out of order");

endmodule

bind dequant_weight_matrix_multiply dwmm_checker u_dwmm_checker (.*);
